// ===== rtl/wvds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wvds_pkg
// Shared types, constants and tables for the wind vector to direction and
// speed pipeline.
// ---------------------------------------------------------------------------
package wvds_pkg;

  // Field widths
  localparam int COMP_W  = 16;   // signed Q8.8 wind component
  localparam int DIR_W   = 15;   // direction, 1/64 degree
  localparam int SPEED_W = 17;   // speed, 1/256 knot

  // Angle path: angles in units of 2^-20 degree
  localparam int XY_W          = 50;  // CORDIC x/y, magnitude scaled by 2^32
  localparam int XY_SHIFT      = 32;
  localparam int Z_W           = 28;  // CORDIC angle accumulator
  localparam int D_W           = 29;  // unsigned direction before rounding
  localparam int ANG_W         = 31;  // signed working width for direction sums
  localparam int CORDIC_STEPS  = 21;

  localparam logic signed [ANG_W-1:0] ANGLE_90  = ANG_W'(94371840);
  localparam logic signed [ANG_W-1:0] ANGLE_270 = ANG_W'(283115520);
  localparam logic signed [ANG_W-1:0] ANGLE_450 = ANG_W'(471859200);
  localparam logic [D_W-1:0]          ANGLE_360 = D_W'(377487360);

  localparam int OUT_SHIFT = 14;
  localparam logic [D_W:0]       DIR_ROUND = (D_W+1)'(8192);
  localparam logic [D_W-OUT_SHIFT:0] DIR_FULL = (D_W-OUT_SHIFT+1)'(23040);

  // Speed path
  localparam int SUM_W     = 32;  // u^2 + v^2
  localparam int SQR_W     = 31;  // one square
  localparam int SQ_W      = 63;  // radicand and root register
  localparam int ROOT_W    = 32;  // final integer root
  localparam int NUM_CELLS = 32;  // one root bit per cell
  localparam int STEP_W    = 5;
  localparam logic [ROOT_W:0] SPEED_ROUND = (ROOT_W+1)'(16384);
  localparam int SPEED_SHIFT = 15;

  // Conversion factor 1 / 0.514444^2 in Q30, truncated
  localparam longint unsigned KNOT_NUM  = 64'd1000000000000;
  localparam longint unsigned KNOT_DEN  = 64'd264652629136;
  localparam longint unsigned KNOT_QINT = KNOT_NUM / KNOT_DEN;
  localparam longint unsigned KNOT_RINT = KNOT_NUM % KNOT_DEN;

  function automatic logic [31:0] knot_factor_q30();
    longint unsigned q;
    longint unsigned r;
    q = KNOT_QINT;
    r = KNOT_RINT;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= KNOT_DEN) begin
        r = r - KNOT_DEN;
        q = q | 64'd1;
      end
    end
    return q[31:0];
  endfunction

  localparam logic [31:0] KNOT_Q30 = knot_factor_q30();

  // atan(2^-i) in units of 2^-20 degree, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      5'd0:    val = Z_W'(47185920);
      5'd1:    val = Z_W'(27855475);
      5'd2:    val = Z_W'(14718068);
      5'd3:    val = Z_W'(7471121);
      5'd4:    val = Z_W'(3750058);
      5'd5:    val = Z_W'(1876857);
      5'd6:    val = Z_W'(938658);
      5'd7:    val = Z_W'(469357);
      5'd8:    val = Z_W'(234682);
      5'd9:    val = Z_W'(117342);
      5'd10:   val = Z_W'(58671);
      5'd11:   val = Z_W'(29335);
      5'd12:   val = Z_W'(14668);
      5'd13:   val = Z_W'(7334);
      5'd14:   val = Z_W'(3667);
      5'd15:   val = Z_W'(1833);
      5'd16:   val = Z_W'(917);
      5'd17:   val = Z_W'(458);
      5'd18:   val = Z_W'(229);
      5'd19:   val = Z_W'(115);
      5'd20:   val = Z_W'(57);
      default: val = '0;
    endcase
    return val;
  endfunction

  // Payload handed from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        rem;
    logic [SQ_W-1:0]        root;
    logic                   u_neg;
    logic                   v_neg;
    logic                   u_zero;
    logic                   v_zero;
    logic                   missing;
  } lane_t;

endpackage
`default_nettype wire

// ===== rtl/wind_vector_to_direction_speed.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wind_vector_to_direction_speed
// Converts east/north wind components into meteorological direction, speed
// in knots and a missing-point flag, one grid point per cycle unless stalled.
// ---------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   vec      | vec_valid/vec_stall  | wind_east, wind_north (Q8.8 m/s)
//   res      | res_valid/res_stall  | direction, speed_knots, is_missing
//   cfg      | cfg_write            | cfg_data -> missing_code
//
// One transfer per cycle sustained while res_stall is low; 3 front stages, a
// chain of 32 cells, 3 finish stages. The square root sets the chain length,
// settling one root bit per cell; the CORDIC rides in the first 21 of them.
// rst (synchronous) empties every stage and sets missing_code to -32768.
// Each stage only holds while it is full and the stage after it holds, so
// bubbles close up behind a stalled result: vec_stall rises only once every
// stage holds a point and res_stall is high.
//
module wind_vector_to_direction_speed (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vec_valid,
  output logic                                vec_stall,
  input  logic signed [wvds_pkg::COMP_W-1:0]  wind_east,
  input  logic signed [wvds_pkg::COMP_W-1:0]  wind_north,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [wvds_pkg::DIR_W-1:0]          direction,
  output logic [wvds_pkg::SPEED_W-1:0]        speed_knots,
  output logic                                is_missing,
  input  logic                                cfg_write,
  input  logic signed [wvds_pkg::COMP_W-1:0]  cfg_data
);

  localparam int NUM_CELLS = wvds_pkg::NUM_CELLS;
  localparam int STEP_W    = wvds_pkg::STEP_W;

  logic signed [wvds_pkg::COMP_W-1:0] missing_code;

  // chain links: entry k feeds cell k, entry NUM_CELLS feeds the finish stages
  wvds_pkg::lane_t lane  [NUM_CELLS+1];
  logic            valid [NUM_CELLS+1];
  logic            ready [NUM_CELLS+1];
  logic            front_ready;

  // sentinel register: hold until written
  always_ff @(posedge clk) begin
    if (rst) begin
      missing_code <= {1'b1, {(wvds_pkg::COMP_W-1){1'b0}}};
    end else if (cfg_write) begin
      missing_code <= cfg_data;
    end
  end

  assign vec_stall = !front_ready;

  // magnitudes, squares and knot scaling
  wvds_front u_front (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (vec_valid),
    .up_ready     (front_ready),
    .wind_east    (wind_east),
    .wind_north   (wind_north),
    .missing_code (missing_code),
    .dn_valid     (valid[0]),
    .dn_lane      (lane[0]),
    .dn_ready     (ready[0])
  );

  // advance angle and root one step per cell
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    wvds_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (STEP_W'(k)),
      .up_valid (valid[k]),
      .up_ready (ready[k]),
      .up_lane  (lane[k]),
      .dn_valid (valid[k+1]),
      .dn_lane  (lane[k+1]),
      .dn_ready (ready[k+1])
    );
  end

  // quadrant fold, wrap and rounding; the last stage is the result register
  wvds_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (valid[NUM_CELLS]),
    .up_ready    (ready[NUM_CELLS]),
    .up_lane     (lane[NUM_CELLS]),
    .dn_valid    (res_valid),
    .direction   (direction),
    .speed_knots (speed_knots),
    .is_missing  (is_missing),
    .dn_ready    (!res_stall)
  );

`ifndef SYNTHESIS
  // the input side may only be held back when the whole pipe is full and blocked
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    vec_stall |-> (res_valid && res_stall && valid[0] && valid[NUM_CELLS]))
    else $error("input held back while the pipeline still has room");

  // a delivered direction lies within one turn
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (direction < wvds_pkg::DIR_FULL[wvds_pkg::DIR_W-1:0]))
    else $error("direction outside one turn");

  // speed cannot exceed the magnitude of the largest input vector
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (speed_knots <= wvds_pkg::SPEED_W'(90100)))
    else $error("speed beyond the largest possible vector");

  // hold a stalled result unchanged until it is taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(direction)
      && $stable(speed_knots) && $stable(is_missing)))
    else $error("stalled result changed before it was taken");
`endif

endmodule
`default_nettype wire

// ===== rtl/wvds_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wvds_front
// Three-stage front end: magnitudes and squares, sum of squares, knot
// scaling product and seeding of the cell chain.
// ---------------------------------------------------------------------------
module wvds_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [wvds_pkg::COMP_W-1:0]  wind_east,
  input  logic signed [wvds_pkg::COMP_W-1:0]  wind_north,
  input  logic signed [wvds_pkg::COMP_W-1:0]  missing_code,
  output logic                                dn_valid,
  output wvds_pkg::lane_t                     dn_lane,
  input  logic                                dn_ready
);

  localparam int COMP_W   = wvds_pkg::COMP_W;
  localparam int SQR_W    = wvds_pkg::SQR_W;
  localparam int SUM_W    = wvds_pkg::SUM_W;
  localparam int SQ_W     = wvds_pkg::SQ_W;
  localparam int XY_W     = wvds_pkg::XY_W;
  localparam int XY_SHIFT = wvds_pkg::XY_SHIFT;

  logic valid0, valid1, valid2;
  logic ready0, ready1, ready2;

  // stage 0
  logic [COMP_W-1:0] au0, av0;
  logic              un0, vn0, miss0;
  logic [SQR_W-1:0]  usq0, vsq0;
  // stage 1
  logic [COMP_W-1:0] au1, av1;
  logic              un1, vn1, miss1;
  logic [SUM_W-1:0]  sum1;

  logic signed [2*COMP_W-1:0] usq_full, vsq_full;
  logic [2*SUM_W-1:0]         prod;

  assign ready2   = !valid2 || dn_ready;
  assign ready1   = !valid1 || ready2;
  assign ready0   = !valid0 || ready1;
  assign up_ready = ready0;

  assign usq_full = wind_east * wind_east;
  assign vsq_full = wind_north * wind_north;
  assign prod     = sum1 * wvds_pkg::KNOT_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      if (ready0) valid0 <= up_valid;
      if (ready1) valid1 <= valid0;
      if (ready2) valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready0) begin
      au0   <= wind_east[COMP_W-1]  ? $unsigned(-wind_east)  : $unsigned(wind_east);
      av0   <= wind_north[COMP_W-1] ? $unsigned(-wind_north) : $unsigned(wind_north);
      un0   <= wind_east[COMP_W-1];
      vn0   <= wind_north[COMP_W-1];
      miss0 <= (wind_east == missing_code);
      usq0  <= usq_full[SQR_W-1:0];
      vsq0  <= vsq_full[SQR_W-1:0];
    end
    if (ready1) begin
      au1  <= au0;
      av1  <= av0;
      un1  <= un0;
      vn1  <= vn0;
      miss1 <= miss0;
      sum1 <= SUM_W'(usq0) + SUM_W'(vsq0);
    end
    if (ready2) begin
      dn_lane.x       <= $signed(XY_W'({au1, {XY_SHIFT{1'b0}}}));
      dn_lane.y       <= $signed(XY_W'({av1, {XY_SHIFT{1'b0}}}));
      dn_lane.z       <= '0;
      dn_lane.rem     <= prod[SQ_W-1:0];
      dn_lane.root    <= '0;
      dn_lane.u_neg   <= un1;
      dn_lane.v_neg   <= vn1;
      dn_lane.u_zero  <= (au1 == '0);
      dn_lane.v_zero  <= (av1 == '0);
      dn_lane.missing <= miss1;
    end
  end

  assign dn_valid = valid2;

endmodule
`default_nettype wire

// ===== rtl/wvds_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wvds_cell
// One cell of the chain: one vectoring CORDIC rotation (first 21 cells) and
// one bit of the integer square root, then a register.
// ---------------------------------------------------------------------------
module wvds_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [wvds_pkg::STEP_W-1:0]      step,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  wvds_pkg::lane_t                  up_lane,
  output logic                             dn_valid,
  output wvds_pkg::lane_t                  dn_lane,
  input  logic                             dn_ready
);

  localparam int XY_W      = wvds_pkg::XY_W;
  localparam int SQ_W      = wvds_pkg::SQ_W;
  localparam int STEP_W    = wvds_pkg::STEP_W;
  localparam int NUM_CELLS = wvds_pkg::NUM_CELLS;

  // shift right, truncating toward zero
  function automatic logic signed [XY_W-1:0] shr_trunc(
    input logic signed [XY_W-1:0] val,
    input logic [STEP_W-1:0]      sh
  );
    logic signed [XY_W-1:0] fl;
    logic [XY_W-1:0]        mask;
    logic                   lost;
    fl   = val >>> sh;
    mask = ~({XY_W{1'b1}} << sh);
    lost = |(val & mask);
    return fl + $signed({{(XY_W-1){1'b0}}, val[XY_W-1] & lost});
  endfunction

  logic                   valid;
  wvds_pkg::lane_t        lane_next;
  logic signed [XY_W-1:0] xs, ys;
  logic [STEP_W:0]        bit_pos;
  logic [SQ_W-1:0]        sq_bit, trial;

  assign up_ready = !valid || dn_ready;
  assign xs       = shr_trunc(up_lane.x, step);
  assign ys       = shr_trunc(up_lane.y, step);
  assign bit_pos  = {STEP_W'(NUM_CELLS - 1) - step, 1'b0};
  assign sq_bit   = SQ_W'(1) << bit_pos;
  assign trial    = up_lane.root + sq_bit;

  always_comb begin
    lane_next = up_lane;
    // drive y toward zero, accumulate the angle
    if (step < STEP_W'(wvds_pkg::CORDIC_STEPS)) begin
      if (!up_lane.y[XY_W-1]) begin
        lane_next.x = up_lane.x + ys;
        lane_next.y = up_lane.y - xs;
        lane_next.z = up_lane.z + wvds_pkg::atan_entry(step);
      end else begin
        lane_next.x = up_lane.x - ys;
        lane_next.y = up_lane.y + xs;
        lane_next.z = up_lane.z - wvds_pkg::atan_entry(step);
      end
    end
    // settle one root bit
    if (up_lane.rem >= trial) begin
      lane_next.rem  = up_lane.rem - trial;
      lane_next.root = (up_lane.root >> 1) + sq_bit;
    end else begin
      lane_next.root = up_lane.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_lane <= lane_next;
    end
  end

  assign dn_valid = valid;

endmodule
`default_nettype wire

// ===== rtl/wvds_finish.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wvds_finish
// Three-stage back end: quadrant fold, wrap into one turn, rounding to
// 1/64 degree; speed rounding; result register.
// ---------------------------------------------------------------------------
module wvds_finish (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  wvds_pkg::lane_t                     up_lane,
  output logic                                dn_valid,
  output logic [wvds_pkg::DIR_W-1:0]          direction,
  output logic [wvds_pkg::SPEED_W-1:0]        speed_knots,
  output logic                                is_missing,
  input  logic                                dn_ready
);

  localparam int ANG_W       = wvds_pkg::ANG_W;
  localparam int D_W         = wvds_pkg::D_W;
  localparam int DIR_W       = wvds_pkg::DIR_W;
  localparam int SPEED_W     = wvds_pkg::SPEED_W;
  localparam int ROOT_W      = wvds_pkg::ROOT_W;
  localparam int OUT_SHIFT   = wvds_pkg::OUT_SHIFT;
  localparam int SPEED_SHIFT = wvds_pkg::SPEED_SHIFT;

  logic valid_a, valid_b, valid_c;
  logic ready_a, ready_b, ready_c;

  logic [D_W-1:0]     d_raw_a, d_b;
  logic [SPEED_W-1:0] spd_a, spd_b;
  logic               miss_a, miss_b;

  logic signed [ANG_W-1:0] angle, base, d_sum;
  logic                    sub;
  logic [ROOT_W:0]         spd_sum;
  logic [D_W:0]            d_round;
  logic [D_W-OUT_SHIFT:0]  dir_q;

  assign ready_c  = !valid_c || dn_ready;
  assign ready_b  = !valid_b || ready_c;
  assign ready_a  = !valid_a || ready_b;
  assign up_ready = ready_a;

  // direction = 270 - atan2(v,u), folded per quadrant
  always_comb begin
    angle = up_lane.u_zero ? wvds_pkg::ANGLE_90 : ANG_W'(up_lane.z);
    case ({up_lane.u_neg, up_lane.v_neg})
      2'b00:   begin base = wvds_pkg::ANGLE_270; sub = 1'b1; end
      2'b01:   begin base = wvds_pkg::ANGLE_270; sub = 1'b0; end
      2'b10:   begin base = wvds_pkg::ANGLE_90;  sub = 1'b0; end
      2'b11:   begin base = wvds_pkg::ANGLE_450; sub = 1'b1; end
      default: begin base = wvds_pkg::ANGLE_270; sub = 1'b1; end
    endcase
    if (up_lane.u_zero && up_lane.v_zero) begin
      d_sum = wvds_pkg::ANGLE_270;
    end else if (sub) begin
      d_sum = base - angle;
    end else begin
      d_sum = base + angle;
    end
  end

  assign spd_sum = {1'b0, up_lane.root[ROOT_W-1:0]} + wvds_pkg::SPEED_ROUND;
  assign d_round = {1'b0, d_b} + wvds_pkg::DIR_ROUND;
  assign dir_q   = d_round[D_W:OUT_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      if (ready_a) valid_a <= up_valid;
      if (ready_b) valid_b <= valid_a;
      if (ready_c) valid_c <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      d_raw_a <= d_sum[D_W-1:0];
      spd_a   <= spd_sum[SPEED_SHIFT +: SPEED_W];
      miss_a  <= up_lane.missing;
    end
    if (ready_b) begin
      d_b    <= (d_raw_a >= wvds_pkg::ANGLE_360) ? d_raw_a - wvds_pkg::ANGLE_360 : d_raw_a;
      spd_b  <= spd_a;
      miss_b <= miss_a;
    end
    if (ready_c) begin
      direction   <= (dir_q >= wvds_pkg::DIR_FULL) ? '0 : dir_q[DIR_W-1:0];
      speed_knots <= spd_b;
      is_missing  <= miss_b;
    end
  end

  assign dn_valid = valid_c;

endmodule
`default_nettype wire
